FILE: rtl/hjb_pkg.sv
package hjb_pkg;

	// Register file geometry
	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// Default timer width and reset values of the debounce waits
	localparam int unsigned TIMER_BITS_DEF = 16;
	localparam int unsigned JACK_WAIT_INSERT_RST = 500;
	localparam int unsigned JACK_WAIT_REMOVE_RST = 100;
	localparam int unsigned BTN_WAIT_PRESS_RST = 200;
	localparam int unsigned BTN_WAIT_RELEASE_RST = 500;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_JACK_ACTIVE_LEVEL = 3'd0,
		CFG_MIC_SUPPORTED     = 3'd1,
		CFG_JACK_WAIT_INSERT  = 3'd2,
		CFG_JACK_WAIT_REMOVE  = 3'd3,
		CFG_BTN_WAIT_PRESS    = 3'd4,
		CFG_BTN_WAIT_RELEASE  = 3'd5
	} hjb_cfg_idx_t;

	// Reported jack state
	typedef enum logic [1:0] {
		JACK_NONE  = 2'd0,
		JACK_MIC   = 2'd1,
		JACK_NOMIC = 2'd2
	} hjb_jack_t;

	// Input word
	typedef struct packed {
		logic jack_pin;
		logic mic_pin;
	} hjb_in_t;

	// Result word
	typedef struct packed {
		logic [1:0] jack_status;
		logic       status_update;
		logic       key_event;
		logic       key_down;
	} hjb_out_t;

	// Jack events that steer the button qualifier
	typedef struct packed {
		logic insert_mic;
		logic remove;
	} hjb_jack_evt_t;

	// Clamp a constant wait to the counter range of the given width
	function automatic logic [63:0] sat_wait(input int unsigned v, input int unsigned bits);
		logic [63:0] max_v;
		max_v = (64'd1 << bits) - 64'd1;
		return (64'(v) > max_v) ? max_v : 64'(v);
	endfunction

endpackage

FILE: rtl/headset_jack_button_debouncer_unit.sv
// Latency: a result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle unless a full result register stalls; the jack
// and button timers update in a single pass from acceptance to result register.
// in_ready stays high while the result register is empty or being drained.
// Reset (arst_n low) clears all timers and state and loads the register defaults.
module headset_jack_button_debouncer_unit import hjb_pkg::*; #(
	parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hjb_in_t              in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hjb_out_t             out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int unsigned NUM_WAITS = 4;

	logic                  jack_level_q;
	logic                  mic_supported_q;
	logic [CFG_W-1:0]      wait_cfg_q [NUM_WAITS];
	logic [TIMER_BITS-1:0] wait_sat [NUM_WAITS];

	logic          fire;
	hjb_jack_t     status_nxt;
	logic          status_update;
	hjb_jack_evt_t jack_evt;
	logic          key_event;
	logic          key_down;
	logic          out_valid_q;
	hjb_out_t      out_word_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jack_level_q    <= 1'b0;
			mic_supported_q <= 1'b1;
			wait_cfg_q[0]   <= CFG_W'(JACK_WAIT_INSERT_RST);
			wait_cfg_q[1]   <= CFG_W'(JACK_WAIT_REMOVE_RST);
			wait_cfg_q[2]   <= CFG_W'(BTN_WAIT_PRESS_RST);
			wait_cfg_q[3]   <= CFG_W'(BTN_WAIT_RELEASE_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_JACK_ACTIVE_LEVEL: jack_level_q    <= cfg_wdata[0];
				CFG_MIC_SUPPORTED:     mic_supported_q <= cfg_wdata[0];
				CFG_JACK_WAIT_INSERT:  wait_cfg_q[0]   <= cfg_wdata;
				CFG_JACK_WAIT_REMOVE:  wait_cfg_q[1]   <= cfg_wdata;
				CFG_BTN_WAIT_PRESS:    wait_cfg_q[2]   <= cfg_wdata;
				CFG_BTN_WAIT_RELEASE:  wait_cfg_q[3]   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp the waits to the timer range
	for (genvar i = 0; i < NUM_WAITS; i++) begin : g_sat
		if (TIMER_BITS >= CFG_W) begin : g_wide
			assign wait_sat[i] = TIMER_BITS'(wait_cfg_q[i]);
		end else begin : g_narrow
			assign wait_sat[i] = (|wait_cfg_q[i][CFG_W-1:TIMER_BITS]) ? '1 :
				wait_cfg_q[i][TIMER_BITS-1:0];
		end
	end

	// Accept a word whenever the result register can take its result
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	hjb_jack_debounce #(
		.TIMER_BITS(TIMER_BITS)
	) u_jack (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.jack_pin     (in_word.jack_pin),
		.active_level (jack_level_q),
		.mic_supported(mic_supported_q),
		.wait_insert  (wait_sat[0]),
		.wait_remove  (wait_sat[1]),
		.status_nxt   (status_nxt),
		.status_update(status_update),
		.evt          (jack_evt)
	);

	hjb_button_debounce #(
		.TIMER_BITS(TIMER_BITS)
	) u_button (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.mic_pin     (in_word.mic_pin),
		.evt         (jack_evt),
		.wait_press  (wait_sat[2]),
		.wait_release(wait_sat[3]),
		.key_event   (key_event),
		.key_down    (key_down)
	);

	// Hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_word_q.jack_status   <= status_nxt;
			out_word_q.status_update <= status_update;
			out_word_q.key_event     <= key_event;
			out_word_q.key_down      <= key_down;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// A pressed report always comes with a key event
	a_key_down_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.key_down |-> out_word.key_event)
		else $error("key_down without key_event");

	// An empty result register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// Every accepted word yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word produced no result");

endmodule

FILE: rtl/hjb_jack_debounce.sv
module hjb_jack_debounce import hjb_pkg::*; #(
	parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic                  jack_pin,
	input  logic                  active_level,
	input  logic                  mic_supported,
	input  logic [TIMER_BITS-1:0] wait_insert,
	input  logic [TIMER_BITS-1:0] wait_remove,
	output hjb_jack_t             status_nxt,
	output logic                  status_update,
	output hjb_jack_evt_t         evt
);

	localparam logic [TIMER_BITS-1:0] WAIT_RST =
		TIMER_BITS'(sat_wait(JACK_WAIT_REMOVE_RST, TIMER_BITS));

	hjb_jack_t             reported_q;
	logic                  last_level_q;
	logic [TIMER_BITS-1:0] count_q, count_nxt;
	logic                  counting_q, counting_nxt;
	logic [TIMER_BITS-1:0] wait_q, wait_nxt;
	logic                  present;

	// Restart on a disagreeing pin change, count down, settle on expiry
	always_comb begin
		present       = (jack_pin == active_level);
		status_nxt    = reported_q;
		status_update = 1'b0;
		evt           = '0;
		count_nxt     = count_q;
		counting_nxt  = counting_q;
		wait_nxt      = wait_q;
		if (jack_pin != last_level_q && present != (reported_q != JACK_NONE)) begin
			count_nxt    = wait_q;
			counting_nxt = 1'b1;
		end
		if (counting_nxt) begin
			if (count_nxt == '0) begin
				counting_nxt = 1'b0;
				if (!present) begin
					if (reported_q != JACK_NONE) begin
						status_nxt    = JACK_NONE;
						status_update = 1'b1;
						evt.remove    = 1'b1;
						wait_nxt      = wait_remove;
					end
				end else begin
					status_nxt     = mic_supported ? JACK_MIC : JACK_NOMIC;
					evt.insert_mic = mic_supported;
					wait_nxt       = wait_insert;
					status_update  = 1'b1;
				end
			end else begin
				count_nxt = count_nxt - TIMER_BITS'(1);
			end
		end
	end

	// Advance the jack state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q   <= JACK_NONE;
			last_level_q <= 1'b1;
			count_q      <= '0;
			counting_q   <= 1'b0;
			wait_q       <= WAIT_RST;
		end else if (fire) begin
			reported_q   <= status_nxt;
			last_level_q <= jack_pin;
			count_q      <= count_nxt;
			counting_q   <= counting_nxt;
			wait_q       <= wait_nxt;
		end
	end

endmodule

FILE: rtl/hjb_button_debounce.sv
module hjb_button_debounce import hjb_pkg::*; #(
	parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic                  mic_pin,
	input  hjb_jack_evt_t         evt,
	input  logic [TIMER_BITS-1:0] wait_press,
	input  logic [TIMER_BITS-1:0] wait_release,
	output logic                  key_event,
	output logic                  key_down
);

	localparam logic [TIMER_BITS-1:0] WAIT_RST =
		TIMER_BITS'(sat_wait(BTN_WAIT_RELEASE_RST, TIMER_BITS));

	logic                  armed_q, armed_nxt;
	logic                  held_q, held_nxt;
	logic                  last_mic_q, last_mic_nxt;
	logic [TIMER_BITS-1:0] count_q, count_nxt;
	logic                  counting_q, counting_nxt;
	logic [TIMER_BITS-1:0] wait_q, wait_nxt;

	// Disarm on removal, arm on mic insert, then qualify the mic pin
	always_comb begin
		armed_nxt    = armed_q;
		held_nxt     = held_q;
		last_mic_nxt = last_mic_q;
		count_nxt    = count_q;
		counting_nxt = counting_q;
		wait_nxt     = wait_q;
		key_event    = 1'b0;
		key_down     = 1'b0;
		if (evt.remove && armed_q) begin
			armed_nxt    = 1'b0;
			counting_nxt = 1'b0;
			count_nxt    = '0;
			last_mic_nxt = 1'b0;
			if (held_q) begin
				held_nxt  = 1'b0;
				key_event = 1'b1;
			end
		end
		if (evt.insert_mic && !armed_q) begin
			wait_nxt     = wait_press;
			armed_nxt    = 1'b1;
			last_mic_nxt = 1'b0;
		end
		if (armed_nxt) begin
			if (mic_pin != last_mic_nxt) begin
				count_nxt    = wait_nxt;
				counting_nxt = 1'b1;
			end
			last_mic_nxt = mic_pin;
			if (counting_nxt) begin
				if (count_nxt == '0) begin
					counting_nxt = 1'b0;
					key_event    = 1'b1;
					if (mic_pin) begin
						held_nxt = 1'b1;
						key_down = 1'b1;
						wait_nxt = wait_press;
					end else begin
						held_nxt = 1'b0;
						wait_nxt = wait_release;
					end
				end else begin
					count_nxt = count_nxt - TIMER_BITS'(1);
				end
			end
		end
	end

	// Advance the button state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= 1'b0;
			held_q     <= 1'b0;
			last_mic_q <= 1'b0;
			count_q    <= '0;
			counting_q <= 1'b0;
			wait_q     <= WAIT_RST;
		end else if (fire) begin
			armed_q    <= armed_nxt;
			held_q     <= held_nxt;
			last_mic_q <= last_mic_nxt;
			count_q    <= count_nxt;
			counting_q <= counting_nxt;
			wait_q     <= wait_nxt;
		end
	end

endmodule
